// ===== src/srgb_to_cielab_converter_assert.svh =====
// assertion macros for the srgb to cielab converter
// used by srgb_to_cielab_converter in src, no other dependencies
`ifndef SRGB_TO_CIELAB_CONVERTER_ASSERT_SVH
`define SRGB_TO_CIELAB_CONVERTER_ASSERT_SVH
`ifndef SYNTH
`define S2L_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srgb2lab assertion failed");
`define S2L_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srgb2lab assertion failed");
`else
`define S2L_ASSERT(lbl, prop)
`define S2L_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/srgb2lab_pkg.sv =====
// types, constants and constant tables for the srgb to cielab converter
// no dependencies
`default_nettype none
package srgb2lab_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int CHANNEL_BITS = 8;
  localparam int Q_BITS       = 24;
  localparam int ROOT_STEPS   = 26;
  localparam int CBRT_LAT     = 2 * ROOT_STEPS + 1;
  localparam int PIPE_DEPTH   = 5 + CBRT_LAT + 2;
  localparam int OUT_SHIFT    = Q_BITS - FRAC_BITS;

  typedef logic [24:0] q25_t;
  typedef logic [25:0] root_t;
  typedef logic signed [39:0] wide_t;
  typedef q25_t lin_rom_t [256];

  // matrix coefficients times 10000, row per output
  localparam logic [13:0] MAT [3][3] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  // white point division through reciprocal multiply
  localparam logic [41:0] DIV_RECIP [3] = '{
    42'(((64'd1 << 58) + 64'd95046) / 64'd95047),
    42'(((64'd1 << 55) + 64'd9999) / 64'd10000),
    42'(((64'd1 << 58) + 64'd108882) / 64'd108883)
  };
  localparam int DIV_SHIFT [3] = '{58, 55, 58};
  localparam logic [3:0] DIV_SCALE [3] = '{4'd10, 4'd1, 4'd10};
  localparam logic [16:0] DIV_ADD [3] = '{17'd47523, 17'd5000, 17'd54441};

  // linear segment of f
  localparam logic [14:0] F_SLOPE     = 15'd24389;
  localparam logic [31:0] F_KNEE      = 32'(64'd216 << 24);
  localparam logic [34:0] F_LIN_ADD   = 35'((64'd432 << 24) + 64'd1566);
  localparam logic [34:0] F_LIN_RECIP = 35'(((64'd1 << 46) + 64'd3131) / 64'd3132);
  localparam int          F_LIN_SHIFT = 46;

  // gamma curve divisors
  localparam longint unsigned CHAN_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned LIN_DEN  = 64'd1292 * CHAN_MAX;
  localparam longint unsigned POW_DEN  = 64'd1055 * CHAN_MAX;
  localparam longint unsigned POW_HALF = POW_DEN / 64'd2;

  function automatic longint unsigned trunc_power(longint unsigned y, int n);
    longint unsigned p;
    p = y;
    for (int i = 1; i < n; i++) begin
      p = (p * y) >> Q_BITS;
    end
    return p;
  endfunction

  function automatic longint unsigned fixed_root(longint unsigned t, int n);
    longint unsigned y;
    longint unsigned c;
    y = 0;
    for (int b = ROOT_STEPS - 1; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (trunc_power(c, n) <= t) begin
        y = c;
      end
    end
    return y;
  endfunction

  function automatic q25_t lin_entry(int unsigned ci);
    longint unsigned c;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned y;
    c = longint'(ci);
    if (c * 64'd100000 <= 64'd4045 * CHAN_MAX) begin
      return q25_t'((c * 64'd100 * (64'd1 << Q_BITS) + 64'd646 * CHAN_MAX) / LIN_DEN);
    end
    t   = ((64'd1000 * c + 64'd55 * CHAN_MAX) * (64'd1 << Q_BITS) + POW_HALF) / POW_DEN;
    t2  = (t * t + (64'd1 << (Q_BITS - 1))) >> Q_BITS;
    y   = fixed_root(t2, 5);
    return q25_t'((t2 * y + (64'd1 << (Q_BITS - 1))) >> Q_BITS);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = lin_entry(i);
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

  // shift right rounding half away from zero
  function automatic wide_t round_shift(wide_t v);
    wide_t half;
    half = wide_t'(1) <<< (OUT_SHIFT - 1);
    if (v >= 0) begin
      return (v + half) >>> OUT_SHIFT;
    end
    return -((-v + half) >>> OUT_SHIFT);
  endfunction

  function automatic logic [14:0] sat_light(wide_t v);
    if (v < 0) begin
      return 15'd0;
    end
    if (v > 40'sd32767) begin
      return 15'h7fff;
    end
    return v[14:0];
  endfunction

  function automatic logic [15:0] sat_chroma(wide_t v);
    if (v < -40'sd32768) begin
      return 16'h8000;
    end
    if (v > 40'sd32767) begin
      return 16'h7fff;
    end
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/srgb_to_cielab_converter.sv =====
// pipeline: 60 register stages from the input lookup to the output register
// throughput: one pixel per cycle while the output is not stalled, set by the fully pipelined cube root stages
// a stall at the output freezes the whole pipeline, nothing is dropped or repeated
// reset: synchronous active low, clears the valid bits only
// depends on srgb2lab_pkg, srgb2lab_cbrt and srgb_to_cielab_converter_assert.svh
`default_nettype none
`include "srgb_to_cielab_converter_assert.svh"
module srgb_to_cielab_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [14:0]      out_lightness,
  output logic signed [15:0] out_green_red,
  output logic signed [15:0] out_blue_yellow
);
  import srgb2lab_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [7:0]            chan [3];
  q25_t                  lin_r [3];
  logic [38:0]           prod_r [3][3];
  logic [40:0]           num_r [3];
  logic [41:0]           pp_hh_r [3], pp_hl_r [3], pp_lh_r [3], pp_ll_r [3];
  q25_t                  quo_r [3];
  root_t                 f [3];
  wide_t                 fx_s, fy_s, fz_s;
  wide_t                 l_raw_r, a_raw_r, b_raw_r;
  logic [14:0]           out_lightness_r;
  logic [15:0]           out_green_red_r, out_blue_yellow_r;

  assign en       = !vld_r[PIPE_DEPTH-1] || !out_stall;
  assign in_stall = !en;
  assign chan[0]  = in_red;
  assign chan[1]  = in_green;
  assign chan[2]  = in_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_lane
      logic [40:0] sum;
      logic [83:0] full;
      assign sum  = 41'(prod_r[i][0]) + 41'(prod_r[i][1]) + 41'(prod_r[i][2]);
      assign full = {pp_hh_r[i], 42'b0} + {21'b0, pp_hl_r[i], 21'b0}
                  + {21'b0, pp_lh_r[i], 21'b0} + {42'b0, pp_ll_r[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          lin_r[i] <= LIN_ROM[chan[i]];
          for (int j = 0; j < 3; j++) begin
            prod_r[i][j] <= 39'(lin_r[j]) * 39'(MAT[i][j]);
          end
          num_r[i]   <= sum * 41'(DIV_SCALE[i]) + 41'(DIV_ADD[i]);
          pp_hh_r[i] <= 42'(num_r[i][40:21]) * 42'(DIV_RECIP[i][41:21]);
          pp_hl_r[i] <= 42'(num_r[i][40:21]) * 42'(DIV_RECIP[i][20:0]);
          pp_lh_r[i] <= 42'(num_r[i][20:0]) * 42'(DIV_RECIP[i][41:21]);
          pp_ll_r[i] <= 42'(num_r[i][20:0]) * 42'(DIV_RECIP[i][20:0]);
          quo_r[i]   <= q25_t'(full >> DIV_SHIFT[i]);
        end
      end
      srgb2lab_cbrt u_cbrt (
        .clk   (clk),
        .en    (en),
        .v_in  (quo_r[i]),
        .f_out (f[i])
      );
    end
  endgenerate

  assign fx_s = wide_t'({14'b0, f[0]});
  assign fy_s = wide_t'({14'b0, f[1]});
  assign fz_s = wide_t'({14'b0, f[2]});

  always_ff @(posedge clk) begin
    if (en) begin
      l_raw_r           <= 40'sd116 * fy_s - 40'sd268435456;
      a_raw_r           <= 40'sd500 * (fx_s - fy_s);
      b_raw_r           <= 40'sd200 * (fy_s - fz_s);
      out_lightness_r   <= sat_light(round_shift(l_raw_r));
      out_green_red_r   <= sat_chroma(round_shift(a_raw_r));
      out_blue_yellow_r <= sat_chroma(round_shift(b_raw_r));
    end
  end

  assign out_valid       = vld_r[PIPE_DEPTH-1];
  assign out_lightness   = out_lightness_r;
  assign out_green_red   = out_green_red_r;
  assign out_blue_yellow = out_blue_yellow_r;

  `S2L_ASSERT_ALWAYS(a_reset_clears, !$past(rst_n) |-> !out_valid)
  `S2L_ASSERT(a_frozen_pipe, in_stall |=> $stable(vld_r))
  `S2L_ASSERT(a_light_range, out_valid |-> out_lightness <= 15'd25600)

endmodule
`default_nettype wire

// ===== src/srgb2lab_cbrt.sv =====
// pipelined lab f function: bit-serial cube root stages plus linear segment
// depends on srgb2lab_pkg
`default_nettype none
module srgb2lab_cbrt (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire srgb2lab_pkg::q25_t   v_in,
  output srgb2lab_pkg::root_t       f_out
);
  import srgb2lab_pkg::*;

  localparam int LIN_DLY = 2 * ROOT_STEPS - 2;

  root_t       y_r  [ROOT_STEPS];
  q25_t        v_r  [ROOT_STEPS];
  logic [51:0] sq_r [ROOT_STEPS];
  root_t       c_r  [ROOT_STEPS];
  root_t       ya_r [ROOT_STEPS];
  q25_t        va_r [ROOT_STEPS];

  genvar k;
  generate
    for (k = 0; k < ROOT_STEPS; k++) begin : g_step
      root_t       y_in;
      q25_t        v_k;
      root_t       c;
      logic [53:0] cube_full;
      logic [29:0] cube;
      if (k == 0) begin : g_first
        assign y_in = '0;
        assign v_k  = v_in;
      end else begin : g_next
        assign y_in = y_r[k-1];
        assign v_k  = v_r[k-1];
      end
      assign c         = y_in | (root_t'(1) << (ROOT_STEPS - 1 - k));
      assign cube_full = 54'(sq_r[k][51:24]) * 54'(c_r[k]);
      assign cube      = cube_full[53:24];
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[k] <= 52'(c) * 52'(c);
          c_r[k]  <= c;
          ya_r[k] <= y_in;
          va_r[k] <= v_k;
          y_r[k]  <= (cube <= 30'(va_r[k])) ? c_r[k] : ya_r[k];
          v_r[k]  <= va_r[k];
        end
      end
    end
  endgenerate

  // linear segment, divide by 3132 through reciprocal
  logic [34:0] n_r;
  logic [35:0] pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [69:0] lin_full;
  root_t       lin_d_r [LIN_DLY];
  logic        knee_sel;
  root_t       f_r;

  assign lin_full = {pp_hh_r, 34'b0} + {17'b0, pp_hl_r, 17'b0} + {17'b0, pp_lh_r, 17'b0}
                  + {34'b0, pp_ll_r};
  assign knee_sel = (40'(v_r[ROOT_STEPS-1]) * 40'(F_SLOPE)) > 40'(F_KNEE);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r     <= 35'(v_in[17:0]) * 35'(F_SLOPE) + F_LIN_ADD;
      pp_hh_r <= 36'(n_r[34:17]) * 36'(F_LIN_RECIP[34:17]);
      pp_hl_r <= 36'(n_r[34:17]) * 36'(F_LIN_RECIP[16:0]);
      pp_lh_r <= 36'(n_r[16:0]) * 36'(F_LIN_RECIP[34:17]);
      pp_ll_r <= 36'(n_r[16:0]) * 36'(F_LIN_RECIP[16:0]);
      lin_d_r[0] <= root_t'(lin_full >> F_LIN_SHIFT);
      for (int i = 1; i < LIN_DLY; i++) begin
        lin_d_r[i] <= lin_d_r[i-1];
      end
      f_r <= knee_sel ? y_r[ROOT_STEPS-1] : lin_d_r[LIN_DLY-1];
    end
  end

  assign f_out = f_r;

endmodule
`default_nettype wire

// ===== verif/srgb_to_cielab_converter_tb.sv =====
// self-checking testbench for the srgb to cielab converter, random pixels with bursty input
// and a stalling output; a scoreboard class predicts l, a, b for each accepted transaction
// depends on srgb_to_cielab_converter and srgb2lab_pkg
`timescale 1ns / 1ps
module srgb_to_cielab_converter_tb;
  import srgb2lab_pkg::*;

  typedef struct packed {
    logic [14:0] lightness;
    logic [15:0] green_red;
    logic [15:0] blue_yellow;
  } lab_t;

  class lab_scoreboard;
    lab_t pending[$];
    int mismatches;
    int checked;

    function longint unsigned pow_q(longint unsigned y, int n);
      longint unsigned p;
      p = y;
      for (int i = 1; i < n; i++) p = (p * y) >> 24;
      return p;
    endfunction

    function longint unsigned root_q(longint unsigned t, int n);
      longint unsigned y;
      longint unsigned c;
      y = 0;
      for (int k = 25; k >= 0; k--) begin
        c = y | (64'd1 << k);
        if (pow_q(c, n) <= t) y = c;
      end
      return y;
    endfunction

    function longint unsigned decode_gamma(logic [7:0] code);
      longint unsigned c;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned den;
      c = code;
      if (c * 100000 <= 4045 * 255)
        return (c * 100 * (64'd1 << 24) + 646 * 255) / (1292 * 255);
      den = 1055 * 255;
      t = ((1000 * c + 55 * 255) * (64'd1 << 24) + den / 2) / den;
      t2 = (t * t + (64'd1 << 23)) >> 24;
      return (t2 * root_q(t2, 5) + (64'd1 << 23)) >> 24;
    endfunction

    function longint unsigned lab_curve(longint unsigned v);
      if (v * 24389 > (64'd216 << 24)) return root_q(v, 3);
      return (v * 24389 + (64'd432 << 24) + 1566) / 3132;
    endfunction

    function longint round_q(longint v);
      longint half;
      half = 64'sd1 <<< (24 - FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> (24 - FRAC_BITS);
      return -((-v + half) >>> (24 - FRAC_BITS));
    endfunction

    function void note_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
      longint unsigned r, g, b, sx, sy, sz;
      longint fx, fy, fz, l, a, bb;
      lab_t e;
      r = decode_gamma(r8);
      g = decode_gamma(g8);
      b = decode_gamma(b8);
      sx = 4124 * r + 3576 * g + 1805 * b;
      sy = 2126 * r + 7152 * g + 722 * b;
      sz = 193 * r + 1192 * g + 9505 * b;
      fx = lab_curve((sx * 10 + 47523) / 95047);
      fy = lab_curve((sy + 5000) / 10000);
      fz = lab_curve((sz * 10 + 54441) / 108883);
      l = round_q(116 * fy - 16 * (64'sd1 <<< 24));
      a = round_q(500 * (fx - fy));
      bb = round_q(200 * (fy - fz));
      l = l < 0 ? 0 : (l > 32767 ? 32767 : l);
      a = a < -32768 ? -32768 : (a > 32767 ? 32767 : a);
      bb = bb < -32768 ? -32768 : (bb > 32767 ? 32767 : bb);
      e.lightness = l[14:0];
      e.green_red = a[15:0];
      e.blue_yellow = bb[15:0];
      pending.push_back(e);
    endfunction

    function void check_lab(lab_t got);
      lab_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction l=%0d", got.lightness);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected l=%0d a=%0d b=%0d, got l=%0d a=%0d b=%0d",
                   e.lightness, $signed(e.green_red), $signed(e.blue_yellow),
                   got.lightness, $signed(got.green_red), $signed(got.blue_yellow));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic out_valid;
  logic out_stall;
  logic [14:0] out_lightness;
  logic signed [15:0] out_green_red;
  logic signed [15:0] out_blue_yellow;

  lab_scoreboard board;
  int stall_mode = 0;

  srgb_to_cielab_converter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lightness(out_lightness), .out_green_red(out_green_red),
    .out_blue_yellow(out_blue_yellow)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  // drive one pixel; valid stays high across back-to-back transactions
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    in_red <= 8'($urandom);
    in_green <= 8'($urandom);
    in_blue <= 8'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // accepted results, sampled at the rising edge
  always @(posedge clk) begin
    lab_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.lightness = out_lightness;
      got.green_red = out_green_red;
      got.blue_yellow = out_blue_yellow;
      board.check_lab(got);
    end
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  always begin
    repeat ($urandom_range(20, 200)) @(negedge clk);
    stall_mode = $urandom_range(0, 2);
  end

  initial begin
    int n;
    logic [7:0] v;
    board = new();
    rst_n = 0;
    in_valid = 0;
    in_red = 0;
    in_green = 0;
    in_blue = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // corners, gray ramp edges, primaries, linear/power knee (codes 10 and 11)
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd10, 8'd11, 8'd254);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd20, 8'd0, 8'd0);

    n = 0;
    while (n < 1300) begin
      repeat ($urandom_range(1, 40)) begin
        case ($urandom_range(0, 3))
          0: begin
            v = 8'($urandom_range(0, 30));
            send_pixel(v, 8'(v + $urandom_range(0, 3)), v);
          end
          1: begin
            v = 8'($urandom);
            send_pixel(v, v, v);
          end
          default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("sent %0d pixels incl. corners, primaries and the gamma knee; %0d results checked",
             n + 17, board.checked);
    $display("bursty input with gaps, output stalled in idle, light and heavy phases");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
